/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for concurrent checks, sampled on clk, with and without a reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define RHA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("ring heap allocator check failed");

// check a property on every clock edge, reset included
`define RHA_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("ring heap allocator check failed");

`endif

/* rtl/core/rha_pkg.sv */
// ----------------------------------------------------------------------------
// rha_pkg
// Types, constants and codes shared by the ring heap allocator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rha_pkg;

	localparam int NUM_RINGS      = 4;
	localparam int SLOTS_PER_RING = 64;
	localparam int TASK_DEPTH     = 256;
	localparam int ALIGN_BYTES    = 64;
	localparam int OFFSET_BITS    = 32;

	localparam int RSEL_W     = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;
	localparam int CNT_W      = $clog2(SLOTS_PER_RING) + 1;
	localparam int SLOT_TOTAL = NUM_RINGS * SLOTS_PER_RING;
	localparam int LOC_W      = $clog2(SLOT_TOTAL);
	localparam int TASK_W     = $clog2(TASK_DEPTH);
	localparam int NEXT_W     = TASK_W + 1;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_SIZE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHUTDOWN  = 1'b1;

	typedef enum logic [1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_CLEAR   = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_HEAP_FULL   = 3'd1,
		ST_DISABLED    = 3'd2,
		ST_TOO_LARGE   = 3'd3,
		ST_SHUTDOWN    = 3'd4,
		ST_TABLE_FULL  = 3'd5,
		ST_NOT_DRAINED = 3'd6,
		ST_IGNORED     = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_LOC,
		S_CHK,
		S_ADV,
		S_AWAIT,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [1:0]  ring_index;
		logic [31:0] request_bytes;
		logic [7:0]  task_slot;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  task_id;
		logic [31:0] heap_offset;
		logic [31:0] slab_end;
		logic [1:0]  used_ring;
		logic [8:0]  live_count;
	} result_t;

	typedef struct packed {
		logic cap;
		logic exec;
		logic flag_rd;
		logic rel_check;
		logic adv_rd;
		logic adv_step;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_release;
		logic rel_ok;
		logic adv_more;
		logic adv_flag;
	} dp_stat_t;

endpackage
`default_nettype wire

/* rtl/core/ring_heap_allocator_inorder_reclaim.sv */
// ----------------------------------------------------------------------------
// ring_heap_allocator_inorder_reclaim
// Circular heap allocator over four rings with in-order tail reclaim.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result shows on
// result for one cycle with done high and must be captured then, since the
// receiver cannot stall. Allocate, clear and unknown commands go from decode
// straight to the response state, which strobes done, and free the port in
// the cycle after done. A refused release passes decode, slot lookup and the
// release check before the response. An accepted release then walks the
// ring's tail: each step reads the released flag and the end offset from
// memory, whose registered read ports set the pace of the walk, and the walk
// stops when no slot is left or on a slot still in use. Configuration writes
// (cfg_we) take effect at once and may be issued at any idle time.
`timescale 1ns / 1ps
`default_nettype none
module ring_heap_allocator_inorder_reclaim (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire rha_pkg::req_t                 req,
	output logic                               done,
	output rha_pkg::result_t                   result,
	input  wire logic                          cfg_we,
	input  wire logic [rha_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                   cfg_data
);

	rha_pkg::ctrl_cmd_t cmd;
	rha_pkg::dp_stat_t  stat;

	rha_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	rha_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

endmodule
`default_nettype wire

/* rtl/core/rha_ram.sv */
// ----------------------------------------------------------------------------
// rha_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

/* rtl/core/rha_ctrl.sv */
// ----------------------------------------------------------------------------
// rha_ctrl
// Sequencer: decode, release lookup, in-order tail walk, result strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rha_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire rha_pkg::dp_stat_t    stat,
	output logic                      busy,
	output logic                      done,
	output rha_pkg::ctrl_cmd_t        cmd
);

	rha_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rha_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rha_pkg::S_IDLE: begin
				if (start) state_d = rha_pkg::S_DECODE;
			end
			rha_pkg::S_DECODE: begin
				state_d = stat.is_release ? rha_pkg::S_LOC : rha_pkg::S_RESP;
			end
			rha_pkg::S_LOC: state_d = rha_pkg::S_CHK;
			rha_pkg::S_CHK: begin
				state_d = stat.rel_ok ? rha_pkg::S_ADV : rha_pkg::S_RESP;
			end
			rha_pkg::S_ADV: begin
				state_d = stat.adv_more ? rha_pkg::S_AWAIT : rha_pkg::S_RESP;
			end
			rha_pkg::S_AWAIT: begin
				state_d = stat.adv_flag ? rha_pkg::S_ADV : rha_pkg::S_RESP;
			end
			rha_pkg::S_RESP: state_d = rha_pkg::S_IDLE;
			default:         state_d = rha_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			rha_pkg::S_IDLE: begin
				busy    = 1'b0;
				cmd.cap = start;
			end
			rha_pkg::S_DECODE: cmd.exec      = 1'b1;
			rha_pkg::S_LOC:    cmd.flag_rd   = 1'b1;
			rha_pkg::S_CHK:    cmd.rel_check = 1'b1;
			rha_pkg::S_ADV:    cmd.adv_rd    = stat.adv_more;
			rha_pkg::S_AWAIT:  cmd.adv_step  = stat.adv_flag;
			rha_pkg::S_RESP:   done          = 1'b1;
			default:           busy          = 1'b1;
		endcase
	end

endmodule
`default_nettype wire

/* rtl/core/rha_dp.sv */
// ----------------------------------------------------------------------------
// rha_dp
// Ring registers, slot tables, allocate check and tail advance datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rha_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire rha_pkg::ctrl_cmd_t                cmd,
	output rha_pkg::dp_stat_t                      stat,
	input  wire rha_pkg::req_t                     req,
	input  wire logic                              cfg_we,
	input  wire logic [rha_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [31:0]                       cfg_data,
	output rha_pkg::result_t                       result
);

	localparam int OW = rha_pkg::OFFSET_BITS;

	rha_pkg::req_t    req_q;
	rha_pkg::result_t res_q, res_d;

	logic [OW-1:0]                  heap_q;
	logic                           shut_q;
	logic [OW-1:0]                  top_q    [rha_pkg::NUM_RINGS];
	logic [OW-1:0]                  tail_q   [rha_pkg::NUM_RINGS];
	logic [rha_pkg::CNT_W-1:0]      oldest_q [rha_pkg::NUM_RINGS];
	logic [rha_pkg::CNT_W-1:0]      count_q  [rha_pkg::NUM_RINGS];
	logic [rha_pkg::NEXT_W-1:0]     next_q;
	logic [8:0]                     live_q;
	logic [rha_pkg::RSEL_W-1:0]     rsel_q;

	// allocate check
	logic [rha_pkg::RSEL_W-1:0] ring_a;
	logic [OW:0]                sum_a, need_a;
	logic [OW-1:0]              need_o, top_a, tail_a, room_a, start_a, end_a;
	logic                       fit_a, table_full, drained;
	logic [rha_pkg::LOC_W-1:0]  loc_a;
	rha_pkg::status_t           alloc_status;

	// release and advance
	logic [rha_pkg::LOC_W-1:0]  loc_rd, end_idx;
	logic [rha_pkg::RSEL_W-1:0] rel_ring;
	logic [rha_pkg::CNT_W-1:0]  rel_k;
	logic [OW-1:0]              end_rd;
	logic                       loc_we, end_we;

	// released flags, cleared per slot when the slot is granted
	logic                       flag_we, flag_wdata, flag_re, flag_rd;
	logic [rha_pkg::LOC_W-1:0]  flag_waddr, flag_raddr;

	always_comb begin
		if (req_q.ring_index >= rha_pkg::NUM_RINGS) begin
			ring_a = rha_pkg::RSEL_W'(rha_pkg::NUM_RINGS - 1);
		end else begin
			ring_a = rha_pkg::RSEL_W'(req_q.ring_index);
		end
		sum_a  = (OW+1)'(req_q.request_bytes) + (OW+1)'(rha_pkg::ALIGN_BYTES - 1);
		need_a = (OW+1)'((sum_a / rha_pkg::ALIGN_BYTES) * rha_pkg::ALIGN_BYTES);
		need_o = need_a[OW-1:0];
		top_a  = top_q[ring_a];
		tail_a = tail_q[ring_a];
		room_a = (top_a <= heap_q) ? heap_q - top_a : '0;
		fit_a   = 1'b0;
		start_a = top_a;
		end_a   = top_a;
		if (need_a != '0) begin
			if (top_a >= tail_a) begin
				if (room_a >= need_o) begin
					fit_a = 1'b1;
					end_a = top_a + need_o;
				end else if (tail_a > need_o) begin
					fit_a   = 1'b1;
					start_a = '0;
					end_a   = need_o;
				end
			end else if (tail_a - top_a > need_o) begin
				fit_a = 1'b1;
				end_a = top_a + need_o;
			end
		end else begin
			fit_a   = 1'b1;
			start_a = '0;
		end
		table_full = (count_q[ring_a] >= rha_pkg::CNT_W'(rha_pkg::SLOTS_PER_RING)) ||
			(next_q >= rha_pkg::NEXT_W'(rha_pkg::TASK_DEPTH));
		if (req_q.request_bytes != '0 && heap_q == '0) begin
			alloc_status = rha_pkg::ST_DISABLED;
		end else if (need_a > (OW+1)'(heap_q)) begin
			alloc_status = rha_pkg::ST_TOO_LARGE;
		end else if (shut_q) begin
			alloc_status = rha_pkg::ST_SHUTDOWN;
		end else if (table_full) begin
			alloc_status = rha_pkg::ST_TABLE_FULL;
		end else if (!fit_a) begin
			alloc_status = rha_pkg::ST_HEAP_FULL;
		end else begin
			alloc_status = rha_pkg::ST_OK;
		end
		loc_a = rha_pkg::LOC_W'(ring_a * rha_pkg::SLOTS_PER_RING + count_q[ring_a]);
		drained = 1'b1;
		for (int r = 0; r < rha_pkg::NUM_RINGS; r++) begin
			if (oldest_q[r] != count_q[r]) drained = 1'b0;
		end
	end

	always_comb begin
		rel_ring = rha_pkg::RSEL_W'(loc_rd / rha_pkg::SLOTS_PER_RING);
		rel_k    = rha_pkg::CNT_W'(loc_rd % rha_pkg::SLOTS_PER_RING);
		stat.is_release = (req_q.command == rha_pkg::CMD_RELEASE);
		stat.rel_ok = ({1'b0, req_q.task_slot} < next_q) &&
			(rel_k < count_q[rel_ring]) && !flag_rd;
		end_idx = rha_pkg::LOC_W'(rsel_q * rha_pkg::SLOTS_PER_RING + oldest_q[rsel_q]);
		stat.adv_more = (oldest_q[rsel_q] < count_q[rsel_q]);
		stat.adv_flag = flag_rd;
	end

	assign loc_we = cmd.exec && (req_q.command == rha_pkg::CMD_ALLOC) &&
		(alloc_status == rha_pkg::ST_OK);
	assign end_we = loc_we;

	assign flag_we    = loc_we || (cmd.rel_check && stat.rel_ok);
	assign flag_waddr = loc_we ? loc_a : loc_rd;
	assign flag_wdata = !loc_we;
	assign flag_re    = cmd.flag_rd || cmd.adv_rd;
	assign flag_raddr = cmd.flag_rd ? loc_rd : end_idx;

	rha_ram #(.WIDTH(rha_pkg::LOC_W), .DEPTH(rha_pkg::TASK_DEPTH)) u_loc_ram (
		.clk   (clk),
		.we    (loc_we),
		.waddr (next_q[rha_pkg::TASK_W-1:0]),
		.wdata (loc_a),
		.re    (cmd.exec),
		.raddr (rha_pkg::TASK_W'(req_q.task_slot)),
		.rdata (loc_rd)
	);

	rha_ram #(.WIDTH(OW), .DEPTH(rha_pkg::SLOT_TOTAL)) u_end_ram (
		.clk   (clk),
		.we    (end_we),
		.waddr (loc_a),
		.wdata (end_a),
		.re    (cmd.adv_rd),
		.raddr (end_idx),
		.rdata (end_rd)
	);

	rha_ram #(.WIDTH(1), .DEPTH(rha_pkg::SLOT_TOTAL)) u_flag_ram (
		.clk   (clk),
		.we    (flag_we),
		.waddr (flag_waddr),
		.wdata (flag_wdata),
		.re    (flag_re),
		.raddr (flag_raddr),
		.rdata (flag_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_q <= '0;
			shut_q <= 1'b0;
			for (int r = 0; r < rha_pkg::NUM_RINGS; r++) begin
				top_q[r]    <= '0;
				tail_q[r]   <= '0;
				oldest_q[r] <= '0;
				count_q[r]  <= '0;
			end
			next_q <= '0;
			live_q <= '0;
			rsel_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == rha_pkg::CFG_HEAP_SIZE) heap_q <= OW'(cfg_data);
				if (cfg_index == rha_pkg::CFG_SHUTDOWN)  shut_q <= cfg_data[0];
			end
			if (loc_we) begin
				top_q[ring_a]   <= end_a;
				count_q[ring_a] <= count_q[ring_a] + 1'b1;
				next_q          <= next_q + 1'b1;
				live_q          <= live_q + 1'b1;
			end
			if (cmd.exec && req_q.command == rha_pkg::CMD_CLEAR && drained) begin
				for (int r = 0; r < rha_pkg::NUM_RINGS; r++) begin
					top_q[r]    <= '0;
					tail_q[r]   <= '0;
					oldest_q[r] <= '0;
					count_q[r]  <= '0;
				end
				next_q <= '0;
				live_q <= '0;
			end
			if (cmd.rel_check && stat.rel_ok) begin
				rsel_q <= rel_ring;
			end
			if (cmd.adv_step) begin
				tail_q[rsel_q]   <= end_rd;
				oldest_q[rsel_q] <= oldest_q[rsel_q] + 1'b1;
				live_q           <= live_q - 1'b1;
			end
		end
	end

	always_comb begin
		res_d = res_q;
		if (cmd.exec) begin
			res_d = '0;
			case (req_q.command)
				rha_pkg::CMD_ALLOC: begin
					res_d.status    = alloc_status;
					res_d.used_ring = 2'(ring_a);
					if (alloc_status == rha_pkg::ST_OK) begin
						res_d.task_id     = 8'(next_q);
						res_d.heap_offset = 32'(start_a);
						res_d.slab_end    = 32'(end_a);
					end
				end
				rha_pkg::CMD_CLEAR: begin
					res_d.status = drained ? rha_pkg::ST_OK : rha_pkg::ST_NOT_DRAINED;
				end
				default: res_d.status = rha_pkg::ST_IGNORED;
			endcase
		end
		if (cmd.rel_check) begin
			res_d.status = stat.rel_ok ? rha_pkg::ST_OK : rha_pkg::ST_IGNORED;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			req_q <= req;
		end
		res_q <= res_d;
	end

	always_comb begin
		result            = res_q;
		result.live_count = live_q;
	end

endmodule
`default_nettype wire

/* rtl/core/rha_checker.sv */
// ----------------------------------------------------------------------------
// rha_checker
// Port-level checks on the ring heap allocator handshake timing and refused results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rha_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input wire logic             done,
	input wire rha_pkg::result_t result
);

	logic fields_zero;

	assign fields_zero = (result.task_id == 8'd0) && (result.heap_offset == 32'd0) &&
		(result.slab_end == 32'd0);

	`RHA_ASSERT(a_done_pulse, done |=> !done)
	`RHA_ASSERT(a_take_busy, (start && !busy) |=> busy)
	`RHA_ASSERT(a_done_busy, done |-> busy)
	`RHA_ASSERT(a_refuse_zero, (done && result.status != rha_pkg::ST_OK) |-> fields_zero)
	`RHA_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> (!busy && !done))

endmodule

bind ring_heap_allocator_inorder_reclaim rha_checker u_rha_checker (.*);
`default_nettype wire
